### design/acpd_pkg.sv
// acpd_pkg: item types, controller states and command/status bundles
// for the autocorrelation period detector; no dependencies
package acpd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int LAG_BITS    = 10;

    // one input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } acpd_in_t;

    // one result item
    typedef struct packed {
        logic [LAG_BITS-1:0] period_lag;
        logic                peak_mismatch;
        logic                record_truncated;
    } acpd_out_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DEV,
        S_NEXT,
        S_MACGO,
        S_MAC,
        S_DIVGO,
        S_DIV,
        S_STORE,
        S_SCANGO,
        S_SCAN,
        S_MIS,
        S_DONE
    } acpd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dev_run;
        logic mac_init;
        logic mac_run;
        logic div_start;
        logic acv_store;
        logic scan_init;
        logic scan_run;
        logic mis_calc;
        logic load_out;
    } acpd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dev_done;
        logic lag_ok;
        logic mac_done;
        logic div_done;
        logic scan_done;
    } acpd_stat_t;

endpackage

### design/acpd_div.sv
// acpd_div: iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero; depends on nothing
module acpd_div #(
    parameter int DW = 59,
    parameter int VW = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic        [VW-1:0] divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic          neg_reg, neg_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;

    // operand load on start, else one restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DW-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[DW-1];
            quo_next  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sub[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

### design/acpd_ctrl.sv
// acpd_ctrl: controller state machine sequencing load, deviation pass,
// per-lag multiply-accumulate and divide, peak scan, mismatch and result; uses acpd_pkg
module acpd_ctrl
    import acpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       last_sample,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  acpd_stat_t stat,
    output acpd_cmd_t  cmd
);

    acpd_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    logic        in_fire;

    assign in_fire = item_valid && (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire && last_sample) state_next = S_DEV;
            S_DEV:    if (stat.dev_done) state_next = S_NEXT;
            S_NEXT:   state_next = stat.lag_ok ? S_MACGO : S_SCANGO;
            S_MACGO:  state_next = S_MAC;
            S_MAC:    if (stat.mac_done) state_next = S_DIVGO;
            S_DIVGO:  state_next = S_DIV;
            S_DIV:    if (stat.div_done) state_next = S_STORE;
            S_STORE:  state_next = S_NEXT;
            S_SCANGO: state_next = S_SCAN;
            S_SCAN:   if (stat.scan_done) state_next = S_MIS;
            S_MIS:    state_next = S_DONE;
            S_DONE:   if (!ovalid_reg || result_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.load = in_fire;
            S_DEV:    cmd.dev_run = 1'b1;
            S_MACGO:  cmd.mac_init = 1'b1;
            S_MAC:    cmd.mac_run = 1'b1;
            S_DIVGO:  cmd.div_start = 1'b1;
            S_STORE:  cmd.acv_store = 1'b1;
            S_SCANGO: cmd.scan_init = 1'b1;
            S_SCAN:   cmd.scan_run = 1'b1;
            S_MIS:    cmd.mis_calc = 1'b1;
            S_DONE:   cmd.load_out = !ovalid_reg || result_ready;
            default:  cmd = '0;
        endcase
    end

    // result valid flag
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load_out)
            ovalid_next = 1'b1;
        else if (result_ready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = ovalid_reg;

    // a division completes only while waited for
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIV)
        else $error("division finished outside wait state");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !ovalid_reg || result_ready)
        else $error("pending result overwritten");

endmodule

### design/acpd_dp.sv
// acpd_dp: sample, deviation and autocovariance memories, counters,
// multiply-accumulate pipeline, valley/peak tracking; uses acpd_pkg, acpd_div
module acpd_dp
    import acpd_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  acpd_in_t   item,
    input  acpd_cmd_t  cmd,
    output acpd_stat_t stat,
    output acpd_out_t  result
);

    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int ACV_DEPTH = (MAX_SAMPLES * 3) / 4;
    localparam int ACV_AW    = $clog2(ACV_DEPTH);
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int DEV_W     = SAMPLE_BITS + CNT_W + 1;
    localparam int ACC_W     = 2 * DEV_W + CNT_W;
    localparam int CMP_W     = ACC_W + 3;
    localparam int MIS_W     = ACC_W + 6;

    // memories
    logic        [SAMPLE_BITS-1:0] smem [MAX_SAMPLES];
    logic signed [DEV_W-1:0]       dmem [MAX_SAMPLES];
    logic signed [ACC_W-1:0]       amem [ACV_DEPTH];

    // record collection
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    ov_reg, ov_next;
    logic                    full;
    logic [CNT_W+1:0]        lim_w;

    // analysis operands
    logic [CNT_W-1:0]        n_reg, lim_reg, lag_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic                    trunc_reg;

    // deviation pass
    logic [CNT_W-1:0]              dev_i_reg;
    logic                          dv1_reg;
    logic [ADDR_W-1:0]             di1_reg;
    logic signed [SAMPLE_BITS-1:0] sdat_reg;
    logic                          dev_issue;
    logic signed [DEV_W-1:0]       dev_val;

    // multiply-accumulate
    logic [CNT_W-1:0]          mac_i_reg, span_reg;
    logic [CNT_W-1:0]          rb_addr;
    logic                      mac_issue;
    logic                      m1_reg, m2_reg;
    logic signed [DEV_W-1:0]   ra_reg, rb_reg;
    logic signed [2*DEV_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // divide and lag tracking
    logic                    div_done;
    logic signed [ACC_W-1:0] quo;
    logic signed [ACC_W-1:0] p1_reg, p2_reg, mx_reg;
    logic                    valley_reg;
    logic [CNT_W-1:0]        lv_reg;

    // peak scan
    logic [CNT_W-1:0]        sc_addr_reg, first_reg, sj1_reg, pl_reg;
    logic                    sv1_reg, found_reg, scan_issue, hit;
    logic signed [ACC_W-1:0] ard_reg, wb_reg, wc_reg, sv_val, pk_reg;
    logic signed [CMP_W-1:0] b5, mx4;

    // mismatch
    logic signed [ACC_W:0]   dif_s, tot_reg;
    logic        [ACC_W:0]   diff_reg;
    logic        [MIS_W-1:0] diff20;
    logic                    mis;
    acpd_out_t               res_reg;

    // ---------------- collection ----------------
    assign full = cnt_reg >= CNT_W'(MAX_SAMPLES);

    always_comb
    begin
        cnt_next = full ? cnt_reg : cnt_reg + 1'b1;
        sum_next = full ? sum_reg : sum_reg + SUM_W'(item.sample);
        ov_next  = ov_reg | full;
        lim_w    = ({2'b00, cnt_next} + {1'b0, cnt_next, 1'b0}) >> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (item.last_sample)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
                ov_reg  <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
                ov_reg  <= ov_next;
            end
        end
    end

    // sample store write
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
            smem[cnt_reg[ADDR_W-1:0]] <= item.sample;
    end

    // record latched for analysis
    always_ff @(posedge clk)
    begin
        if (cmd.load && item.last_sample)
        begin
            n_reg     <= cnt_next;
            s_reg     <= sum_next;
            trunc_reg <= ov_next;
            lim_reg   <= lim_w[CNT_W-1:0];
        end
    end

    // ---------------- deviation pass ----------------
    assign dev_issue = cmd.dev_run && (dev_i_reg < n_reg);
    assign dev_val   = ($signed({1'b0, n_reg}) * sdat_reg) - DEV_W'(s_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_i_reg <= '0;
            dv1_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                dev_i_reg <= '0;
            else if (dev_issue)
                dev_i_reg <= dev_i_reg + 1'b1;
            dv1_reg <= dev_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        sdat_reg <= $signed(smem[dev_i_reg[ADDR_W-1:0]]);
        di1_reg  <= dev_i_reg[ADDR_W-1:0];
    end

    // deviation store: one write, two reads
    always_ff @(posedge clk)
    begin
        if (dv1_reg)
            dmem[di1_reg] <= dev_val;
        ra_reg <= dmem[mac_i_reg[ADDR_W-1:0]];
        rb_reg <= dmem[rb_addr[ADDR_W-1:0]];
    end

    // ---------------- multiply-accumulate ----------------
    assign rb_addr   = mac_i_reg + lag_reg;
    assign mac_issue = cmd.mac_run && (mac_i_reg < span_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_i_reg <= '0;
            m1_reg    <= 1'b0;
            m2_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.mac_init)
                mac_i_reg <= '0;
            else if (mac_issue)
                mac_i_reg <= mac_i_reg + 1'b1;
            m1_reg <= mac_issue;
            m2_reg <= m1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ra_reg * rb_reg;
        if (cmd.mac_init)
        begin
            acc_reg  <= '0;
            span_reg <= n_reg - lag_reg;
        end
        else if (m2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    acpd_div #(
        .DW (ACC_W),
        .VW (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // ---------------- lag store, valley and maximum ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg    <= '0;
            valley_reg <= 1'b0;
        end
        else if (cmd.load && item.last_sample)
        begin
            lag_reg    <= CNT_W'(1);
            valley_reg <= 1'b0;
        end
        else if (cmd.acv_store)
        begin
            lag_reg <= lag_reg + 1'b1;
            if (!valley_reg && lag_reg > CNT_W'(3) && p1_reg < p2_reg && p1_reg < quo)
                valley_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && item.last_sample)
        begin
            p1_reg <= '0;
            mx_reg <= '0;
            lv_reg <= '0;
        end
        else if (cmd.acv_store)
        begin
            p1_reg <= quo;
            p2_reg <= p1_reg;
            if (!valley_reg)
            begin
                if (lag_reg > CNT_W'(3) && p1_reg < p2_reg && p1_reg < quo)
                    lv_reg <= lag_reg - 1'b1;
            end
            else if (quo > mx_reg)
                mx_reg <= quo;
        end
    end

    // autocovariance store: one write, one read
    always_ff @(posedge clk)
    begin
        if (cmd.acv_store)
            amem[lag_reg[ACV_AW-1:0]] <= quo;
        ard_reg <= amem[sc_addr_reg[ACV_AW-1:0]];
    end

    // ---------------- peak scan ----------------
    assign scan_issue = cmd.scan_run && (sc_addr_reg < lim_reg) && !found_reg;
    assign sv_val     = (sj1_reg == '0) ? '0 : ard_reg;
    assign b5         = (CMP_W'(wc_reg) <<< 2) + CMP_W'(wc_reg);
    assign mx4        = CMP_W'(mx_reg) <<< 2;
    assign hit        = sv1_reg && !found_reg &&
                        ({1'b0, sj1_reg} >= {1'b0, first_reg} + 2'd2) &&
                        (b5 > mx4) && (wc_reg > wb_reg) && (wc_reg > sv_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv1_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            sv1_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            sv1_reg <= scan_issue;
            if (hit)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            sc_addr_reg <= (lv_reg == '0) ? '0 : lv_reg - 1'b1;
            first_reg   <= (lv_reg == '0) ? '0 : lv_reg - 1'b1;
            pl_reg      <= '0;
            pk_reg      <= '0;
        end
        else
        begin
            if (scan_issue)
                sc_addr_reg <= sc_addr_reg + 1'b1;
            if (sv1_reg)
            begin
                wb_reg <= wc_reg;
                wc_reg <= sv_val;
            end
            if (hit)
            begin
                pl_reg <= sj1_reg - 1'b1;
                pk_reg <= wc_reg;
            end
        end
        sj1_reg <= sc_addr_reg;
    end

    // ---------------- mismatch and result ----------------
    assign dif_s  = (ACC_W+1)'(pk_reg) - (ACC_W+1)'(mx_reg);
    assign diff20 = (MIS_W'(diff_reg) << 4) + (MIS_W'(diff_reg) << 2);
    assign mis    = (tot_reg > 0) && ($signed(diff20) > MIS_W'(tot_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.mis_calc)
        begin
            diff_reg <= dif_s[ACC_W] ? $unsigned(-dif_s) : $unsigned(dif_s);
            tot_reg  <= (ACC_W+1)'(pk_reg) + (ACC_W+1)'(mx_reg);
        end
        if (cmd.load_out)
        begin
            res_reg.period_lag       <= LAG_BITS'(pl_reg);
            res_reg.peak_mismatch    <= mis;
            res_reg.record_truncated <= trunc_reg;
        end
    end

    assign result = res_reg;

    // status
    assign stat.dev_done  = !dev_issue && !dv1_reg;
    assign stat.lag_ok    = lag_reg < lim_reg;
    assign stat.mac_done  = !mac_issue && !m1_reg && !m2_reg;
    assign stat.div_done  = div_done;
    assign stat.scan_done = !scan_issue && !sv1_reg;

    // lag writes stay inside the computed range
    a_acv_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acv_store |-> lag_reg < lim_reg && lag_reg != '0)
        else $error("autocovariance write out of range");

    // the divisor is never zero
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> span_reg != '0)
        else $error("zero divisor");

    // a found peak lies strictly inside the scanned range
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> sj1_reg < lim_reg)
        else $error("peak outside range");

endmodule

### design/autocorrelation_period_detector_core.sv
// autocorrelation_period_detector_core: top level, controller plus datapath
// depends on acpd_pkg, acpd_ctrl, acpd_dp, acpd_div
//
//  channel   handshake                    payload
//  input     item_valid / item_ready      item   (acpd_in_t)
//  output    result_valid / result_ready  result (acpd_out_t)
//
// a sample without the last mark is accepted and the core stays ready for the next
// the marked last sample starts analysis: a deviation pass, then per lag a check,
// a multiply-accumulate, a divide and a store of the lag, then a final check, a
// peak scan, the mismatch check and the load of the result register; the shared
// multiplier and divider serve every lag
// item_ready is low during analysis; a result waits in its register for result_ready
// reset clears all control state; memories hold no reset value
module autocorrelation_period_detector_core
    import acpd_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  acpd_in_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output acpd_out_t result
);

    acpd_cmd_t  cmd;
    acpd_stat_t stat;

    acpd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .last_sample  (item.last_sample),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    acpd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

### verif/tb.sv
// tb: self-checking bench for autocorrelation_period_detector_core
// depends on acpd_pkg and the core; drives sample records and checks each result item
`timescale 1ns / 100ps

module tb;
    import acpd_pkg::*;

    localparam int CAPACITY  = 1024;
    localparam int LAG_SPACE = (CAPACITY * 3) / 4;
    localparam int RANDOM_ITEMS = 780;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    acpd_in_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    acpd_out_t result;

    // record held by the predictor
    int        held_samples [CAPACITY];
    int        held_count = 0;
    longint    held_sum = 0;
    bit        held_dropped = 1'b0;

    acpd_out_t expected_periods [$];
    int        errors = 0;
    int        items_sent = 0;
    int        send_idle_pct = 9;
    int        recv_idle_pct = 45;

    // directed stimulus row: typed result only where obvious
    typedef struct {
        int        value;
        bit        last;
        bit        typed;
        acpd_out_t want;
    } stim_row_t;

    autocorrelation_period_detector_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // period search over the held record
    function automatic acpd_out_t find_period();
        longint    dev [CAPACITY];
        longint    acv [LAG_SPACE + 1];
        longint    n, lim, mx, pk, diff, tot, acc;
        int        lv, pl;
        bit        valley;
        acpd_out_t r;
        n = held_count;
        lim = (n * 3) / 4;
        mx = 0;
        pk = 0;
        lv = 0;
        pl = 0;
        valley = 1'b0;
        for (int i = 0; i < n; i++)
            dev[i] = n * held_samples[i] - held_sum;
        acv[0] = 0;
        for (int lag = 1; lag < lim && lag <= LAG_SPACE; lag++)
        begin
            acc = 0;
            for (int i = 0; i < n - lag; i++)
                acc += dev[i] * dev[i + lag];
            acv[lag] = acc / (n - lag);
            if (!valley)
            begin
                if (lag > 3 && acv[lag-1] < acv[lag-2] && acv[lag-1] < acv[lag])
                begin
                    valley = 1'b1;
                    lv = lag - 1;
                end
            end
            else if (acv[lag] > mx)
                mx = acv[lag];
        end
        // first local peak above 0.8 of the maximum
        for (int lag = lv; lag < lim - 1 && lag < LAG_SPACE; lag++)
        begin
            if (lag >= 1 && acv[lag] * 5 > mx * 4 && acv[lag] > acv[lag-1] &&
                acv[lag] > acv[lag+1])
            begin
                pl = lag;
                pk = acv[lag];
                break;
            end
        end
        diff = pk - mx;
        if (diff < 0)
            diff = -diff;
        tot = pk + mx;
        r.period_lag = pl[LAG_BITS-1:0];
        r.peak_mismatch = (tot > 0 && diff * 20 > tot);
        r.record_truncated = held_dropped;
        return r;
    endfunction

    // update the held record for one accepted item; returns 1 with a result
    function automatic bit take_sample(acpd_in_t x, output acpd_out_t r);
        if (held_count < CAPACITY)
        begin
            held_samples[held_count] = int'(x.sample);
            held_count++;
            held_sum += int'(x.sample);
        end
        else
            held_dropped = 1'b1;
        if (!x.last_sample)
            return 1'b0;
        r = find_period();
        held_count = 0;
        held_sum = 0;
        held_dropped = 1'b0;
        return 1'b1;
    endfunction

    // drive one item and wait for its acceptance
    task automatic send_item(int value, bit last, bit typed, acpd_out_t want);
        acpd_in_t  x;
        acpd_out_t r;
        x.sample = value[SAMPLE_BITS-1:0];
        x.last_sample = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= x;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (take_sample(x, r))
            expected_periods.insert(expected_periods.size(), typed ? want : r);
    endtask

    // one record of n samples; shape 0 periodic, 1 noise, 2 constant
    task automatic send_record(int n, int shape);
        int per, amp, nz, ph, v, cst;
        per = $urandom_range(4, 16);
        amp = $urandom_range(50, 2047);
        nz = $urandom_range(0, 300);
        cst = $urandom_range(4095) - 2048;
        for (int i = 0; i < n; i++)
        begin
            ph = i % per;
            case (shape)
                0: begin
                    v = (amp * 2 * (ph < per / 2 ? ph : per - ph)) / (per / 2) - amp;
                    v += $urandom_range(2 * nz) - nz;
                end
                1: v = $urandom_range(4095) - 2048;
                default: v = cst;
            endcase
            if (v > 2047)
                v = 2047;
            if (v < -2048)
                v = -2048;
            // idle mix follows the item count
            if (items_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 45;
            end
            else if (items_sent < (2 * RANDOM_ITEMS) / 3)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(v, i == n - 1, 1'b0, '0);
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        acpd_out_t want;
        if (result_valid && result_ready)
        begin
            if (expected_periods.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result lag=%0d mis=%0b trunc=%0b", $time,
                         result.period_lag, result.peak_mismatch, result.record_truncated);
            end
            else
            begin
                want = expected_periods.pop_front();
                if (result.period_lag !== want.period_lag)
                begin
                    errors++;
                    $display("%0t: period_lag expected %0d actual %0d", $time,
                             want.period_lag, result.period_lag);
                end
                if (result.peak_mismatch !== want.peak_mismatch)
                begin
                    errors++;
                    $display("%0t: peak_mismatch expected %0b actual %0b", $time,
                             want.peak_mismatch, result.peak_mismatch);
                end
                if (result.record_truncated !== want.record_truncated)
                begin
                    errors++;
                    $display("%0t: record_truncated expected %0b actual %0b", $time,
                             want.record_truncated, result.record_truncated);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t rows [$];
        int        n;
        // single marked sample, two-sample and three-sample records: too short for a period
        rows.insert(rows.size(), '{0, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0}});
        rows.insert(rows.size(), '{-2048, 1'b0, 1'b0, '0});
        rows.insert(rows.size(), '{2047, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0}});
        rows.insert(rows.size(), '{2047, 1'b0, 1'b0, '0});
        rows.insert(rows.size(), '{2047, 1'b0, 1'b0, '0});
        rows.insert(rows.size(), '{2047, 1'b1, 1'b1, '{10'd0, 1'b0, 1'b0}});
        // square wave of period 4 between the extremes
        for (int i = 0; i < 16; i++)
            rows.insert(rows.size(), '{((i / 2) % 2) ? 2047 : -2048, i == 15, 1'b0, '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[k])
            send_item(rows[k].value, rows[k].last, rows[k].typed, rows[k].want);

        // random records, mostly periodic, mostly small
        while (items_sent < RANDOM_ITEMS)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 48);
            send_record(n, ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 2));
        end
        item_valid <= 1'b0;

        while (expected_periods.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
